// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication check, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/rpsf_pkg.sv
`default_nettype none
package rpsf_pkg;
    localparam int QueueDepth = 2;

    typedef enum logic [2:0] {
        ST_OK               = 3'd0,
        ST_INVALID_ARG      = 3'd1,
        ST_INVALID_SIZE     = 3'd2,
        ST_NOT_SUPPORTED    = 3'd3,
        ST_INVALID_RESPONSE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        VT_U16 = 3'd0,
        VT_S16 = 3'd1,
        VT_U32 = 3'd2,
        VT_S32 = 3'd3,
        VT_F32 = 3'd4
    } vtype_t;

    // Classified beat: decoded operand as sign/exp/mantissa plus pre-status.
    typedef struct packed {
        logic [2:0]  status;
        logic        a_sign;
        logic [9:0]  a_exp;    // biased exponent, bias 127, may be < 1
        logic [23:0] a_man;    // normalised, bit 23 set unless zero
        logic        a_zero;
        logic        b_sign;
        logic [9:0]  b_exp;
        logic [23:0] b_man;
        logic        b_zero;
    } work_t;

    function automatic logic [4:0] lzc32(input logic [31:0] v);
        logic [4:0] n;
        logic [31:0] x;
        n = '0;
        x = v;
        if (x[31:16] == '0) begin n[4] = 1'b1; x = x << 16; end
        if (x[31:24] == '0) begin n[3] = 1'b1; x = x << 8; end
        if (x[31:28] == '0) begin n[2] = 1'b1; x = x << 4; end
        if (x[31:30] == '0) begin n[1] = 1'b1; x = x << 2; end
        if (x[31] == 1'b0) n[0] = 1'b1;
        return n;
    endfunction
endpackage
`default_nettype wire

// File: sv/register_pair_to_scaled_float.sv
// Path: each beat passes the front register, the queue, the product stage
// and the rounding stage, in that order.
// Throughput: one beat per cycle while out_stall is low; a two-entry queue
// parts the decode front from the two-stage multiply back, which holds on out_stall.
// Reset: rst_n clears all valid flags, queue pointers and the word order
// (high word first); payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module register_pair_to_scaled_float #(
    parameter int QueueDepth = rpsf_pkg::QueueDepth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] reg_first,
    input  wire logic [15:0] reg_second,
    input  wire logic [7:0]  reg_count,
    input  wire logic [2:0]  value_type,
    input  wire logic [31:0] scale_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      value_bits,
    output logic [2:0]       status
);
    logic low_first_reg;
    rpsf_pkg::work_t front_work, q_data;
    logic front_valid, front_take, q_full, q_ne, back_take, take;

    // Hold the word order; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            low_first_reg <= 1'b0;
        else if (cfg_we)
            low_first_reg <= cfg_wdata[0];
    end

    // Advance the front register whenever it empties into the queue.
    assign front_take = front_valid && !q_full;
    assign in_stall   = front_valid && q_full;
    assign take       = in_valid && !in_stall;

    rpsf_front u_front (
        .clk, .rst_n,
        .low_first(low_first_reg),
        .reg_first, .reg_second, .reg_count, .value_type, .scale_bits,
        .take,
        .work_reg(front_work),
        .work_valid_reg(front_valid),
        .work_take(front_take)
    );

    rpsf_queue #(.Depth(QueueDepth)) u_queue (
        .clk, .rst_n,
        .push(front_take), .push_data(front_work), .full(q_full),
        .pop(back_take), .pop_data(q_data), .not_empty(q_ne)
    );

    rpsf_back u_back (
        .clk, .rst_n,
        .work(q_data), .work_valid(q_ne), .work_take(back_take),
        .value_bits, .status, .out_valid, .out_stall
    );

    `ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(value_bits) && $stable(status))
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && status != rpsf_pkg::ST_OK,
        value_bits == 32'd0)
    `ASSERT_IMPL(a_no_pop_empty, clk, rst_n, back_take, q_ne)
endmodule
`default_nettype wire

// File: sv/rpsf_front.sv
`default_nettype none
// Classify the beat, join words, turn integers into rounded binary32 fields.
module rpsf_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 low_first,
    input  wire logic [15:0]          reg_first,
    input  wire logic [15:0]          reg_second,
    input  wire logic [7:0]           reg_count,
    input  wire logic [2:0]           value_type,
    input  wire logic [31:0]          scale_bits,
    input  wire logic                 take,
    output rpsf_pkg::work_t           work_reg,
    output logic                      work_valid_reg,
    input  wire logic                 work_take
);
    logic [31:0] raw;
    logic [31:0] mag;
    logic        neg;
    logic [4:0]  lz;
    logic [31:0] norm;
    logic [24:0] rnd;
    logic        rup;
    rpsf_pkg::work_t work_next;
    logic [22:0] sfrac;
    logic [7:0]  sexp;
    logic [4:0]  slz;
    logic [22:0] rfrac;
    logic [7:0]  rexp;
    logic [4:0]  rlz;

    assign raw = low_first ? {reg_second, reg_first} : {reg_first, reg_second};
    assign sfrac = scale_bits[22:0];
    assign sexp  = scale_bits[30:23];
    assign rfrac = raw[22:0];
    assign rexp  = raw[30:23];
    assign slz = rpsf_pkg::lzc32({sfrac, 9'h1ff});
    assign rlz = rpsf_pkg::lzc32({rfrac, 9'h1ff});

    always_comb
    begin
        case (value_type)
            rpsf_pkg::VT_U16: begin neg = 1'b0; mag = {16'd0, reg_first}; end
            rpsf_pkg::VT_S16: begin
                neg = reg_first[15];
                mag = reg_first[15] ? (32'd0 - {{16{1'b1}}, reg_first})
                                    : {16'd0, reg_first};
            end
            rpsf_pkg::VT_S32: begin
                neg = raw[31];
                mag = raw[31] ? (32'd0 - raw) : raw;
            end
            default: begin neg = 1'b0; mag = raw; end
        endcase
    end

    assign lz   = rpsf_pkg::lzc32(mag);
    assign norm = mag << lz;
    assign rup  = norm[7] & (norm[8] | (norm[6:0] != '0));
    assign rnd  = {1'b0, norm[31:8]} + {24'd0, rup};

    always_comb
    begin
        work_next = '0;
        // scale operand
        work_next.b_sign = scale_bits[31];
        work_next.b_zero = (scale_bits[30:0] == '0);
        if (sexp == '0) begin
            work_next.b_man = {sfrac, 1'b0} << slz;
            work_next.b_exp = 10'd0 - {5'd0, slz};
        end else begin
            work_next.b_man = {1'b1, sfrac};
            work_next.b_exp = {2'd0, sexp};
        end
        // decoded operand
        if (value_type == rpsf_pkg::VT_F32) begin
            work_next.a_sign = raw[31];
            work_next.a_zero = (raw[30:0] == '0);
            if (rexp == '0) begin
                work_next.a_man = {rfrac, 1'b0} << rlz;
                work_next.a_exp = 10'd0 - {5'd0, rlz};
            end else begin
                work_next.a_man = {1'b1, rfrac};
                work_next.a_exp = {2'd0, rexp};
            end
        end else begin
            work_next.a_sign = neg;
            work_next.a_zero = (mag == '0);
            if (rnd[24]) begin
                work_next.a_man = 24'h800000;
                work_next.a_exp = 10'd127 + 10'd32 - {5'd0, lz};
            end else begin
                work_next.a_man = rnd[23:0];
                work_next.a_exp = 10'd127 + 10'd31 - {5'd0, lz};
            end
        end
        if (sexp == 8'hff)
            work_next.status = rpsf_pkg::ST_INVALID_ARG;
        else if (value_type > rpsf_pkg::VT_F32)
            work_next.status = rpsf_pkg::ST_NOT_SUPPORTED;
        else if (reg_count == '0 ||
                 (value_type >= rpsf_pkg::VT_U32 && reg_count < 8'd2))
            work_next.status = rpsf_pkg::ST_INVALID_SIZE;
        else if (value_type == rpsf_pkg::VT_F32 && rexp == 8'hff)
            work_next.status = rpsf_pkg::ST_INVALID_RESPONSE;
        else
            work_next.status = rpsf_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            work_valid_reg <= 1'b0;
        else if (take)
            work_valid_reg <= 1'b1;
        else if (work_take)
            work_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            work_reg <= work_next;
    end
endmodule
`default_nettype wire

// File: sv/rpsf_queue.sv
`default_nettype none
// Two-entry queue between the front and back halves.
module rpsf_queue #(
    parameter int Depth = rpsf_pkg::QueueDepth
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rpsf_pkg::work_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output rpsf_pkg::work_t      pop_data,
    output logic                 not_empty
);
    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
    rpsf_pkg::work_t mem [Depth];
    logic [Aw-1:0] wr_reg, rd_reg;
    logic [Aw:0]   cnt_reg;

    assign full      = (cnt_reg == (Aw+1)'(Depth));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wr_reg <= (wr_reg == Aw'(Depth - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == Aw'(Depth - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (Aw+1)'(push) - (Aw+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end
endmodule
`default_nettype wire

// File: sv/rpsf_back.sv
`default_nettype none
// Multiply two unpacked operands and round to binary32, subnormals kept.
module rpsf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rpsf_pkg::work_t work,
    input  wire logic           work_valid,
    output logic                work_take,
    output logic [31:0]         value_bits,
    output logic [2:0]          status,
    output logic                out_valid,
    input  wire logic           out_stall
);
    // stage 1: product
    logic [47:0] prod_reg;
    logic [10:0] pexp_reg;
    logic        psign_reg, pzero_reg, p1_valid_reg;
    logic [2:0]  pst_reg;
    logic [31:0] vb_reg;
    logic [2:0]  st_reg;
    logic        valid_reg;
    logic        adv1, adv2;

    logic [47:0] prod_n;
    logic [10:0] e;
    logic [10:0] sh;
    logic [49:0] wide;
    logic [23:0] m;
    logic        gbit, sbit, rup;
    logic [24:0] mr;
    logic [10:0] ef;
    logic [31:0] vb_next;
    logic [2:0]  st_next;

    assign adv2 = !valid_reg || !out_stall;
    assign adv1 = !p1_valid_reg || adv2;
    assign work_take = work_valid && adv1;
    assign out_valid = valid_reg;
    assign value_bits = vb_reg;
    assign status = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p1_valid_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (adv1) p1_valid_reg <= work_valid;
            if (adv2) valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1) begin
            prod_reg  <= work.a_man * work.b_man;
            pexp_reg  <= {work.a_exp[9], work.a_exp} + {work.b_exp[9], work.b_exp}
                         - 11'd126;
            psign_reg <= work.a_sign ^ work.b_sign;
            pzero_reg <= work.a_zero | work.b_zero;
            pst_reg   <= work.status;
        end
        if (adv2) begin
            vb_reg <= vb_next;
            st_reg <= st_next;
        end
    end

    // Normalise: product in [2^46, 2^48); bring top to bit 47.
    always_comb
    begin
        prod_n = prod_reg[47] ? prod_reg : {prod_reg[46:0], 1'b0};
        e = prod_reg[47] ? pexp_reg : pexp_reg - 11'd1;
        // e is biased exponent of value prod_n[47:24].x
        if ($signed(e) < 11'sd1) begin
            sh = 11'd1 - e;
            if (sh > 11'd49) sh = 11'd49;
        end else
            sh = '0;
        wide = {prod_n, 2'b00} >> sh[5:0];
        sbit = (sh != '0) && (({prod_n, 2'b00} & ~({50{1'b1}} << sh[5:0])) != '0);
        m    = wide[49:26];
        gbit = wide[25];
        sbit = sbit | (wide[24:0] != '0);
        rup  = gbit & (sbit | m[0]);
        mr   = {1'b0, m} + {24'd0, rup};
        ef   = ($signed(e) < 11'sd1) ? 11'd0 : e;
        if (mr[24]) begin
            ef = ef + 11'd1;
            mr = {1'b0, 1'b1, 23'd0};
        end else if (ef == '0 && mr[23])
            ef = 11'd1;
        st_next = pst_reg;
        vb_next = '0;
        if (pst_reg == rpsf_pkg::ST_OK) begin
            if (pzero_reg)
                vb_next = {psign_reg, 31'd0};
            else if ($signed(ef) >= 11'sd255)
                st_next = rpsf_pkg::ST_INVALID_RESPONSE;
            else
                vb_next = {psign_reg, ef[7:0], mr[22:0]};
        end
    end
endmodule
`default_nettype wire
